>>> design/prd_pkg.sv
// Shared types and constants for the permuted radix digit encoder.
`default_nettype none

package prd_pkg;

  localparam int RESULT_LIMIT = 64;
  localparam int WORD_W       = 16;
  localparam int STEP_W       = 6;

  // Radix-4 iteration counts of the shared divider
  localparam logic [STEP_W-1:0] STEPS_WIDE   = 6'd32;  // full 64-bit dividend
  localparam logic [STEP_W-1:0] STEPS_NARROW = 6'd16;  // 32-bit product in the top half

  localparam logic [1:0] MODE_MIN    = 2'd0;
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_PREFIX = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_RANGE   = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;

  localparam logic [1:0] CFG_WORD_COUNT  = 2'd0;
  localparam logic [1:0] CFG_MULTIPLIER  = 2'd1;
  localparam logic [1:0] CFG_DIGIT_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_index;
    logic              last;
    logic [1:0]        error;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [63:0]       dividend;
    logic [WORD_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [63:0]       quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/prd_div.sv
// Shared iterative divider: 64-bit dividend by 16-bit divisor, two bits per cycle.
`default_nettype none

module prd_div import prd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [63:0]       q_r, q_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  logic [WORD_W:0] t1, t2, d1, d2;
  logic [WORD_W-1:0] r1;
  logic ge1, ge2;

  // two restoring steps per cycle; remainder always stays below the divisor
  always_comb begin
    t1  = {rem_r, q_r[63]};
    d1  = t1 - {1'b0, dvs_r};
    ge1 = (t1 >= {1'b0, dvs_r});
    r1  = ge1 ? d1[WORD_W-1:0] : t1[WORD_W-1:0];
    t2  = {r1, q_r[62]};
    d2  = t2 - {1'b0, dvs_r};
    ge2 = (t2 >= {1'b0, dvs_r});
    rem_nxt = ge2 ? d2[WORD_W-1:0] : t2[WORD_W-1:0];
    q_nxt   = {q_r[61:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r   <= req.dividend;
        rem_r <= '0;
        dvs_r <= req.divisor;
        cnt_r <= req.steps;
        run_r <= 1'b1;
      end else if (run_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

>>> design/prd_seq.sv
// Digit sequencer: splits the value, holds the digits and emits permuted indexes.
`default_nettype none

module prd_seq import prd_pkg::*; #(
  parameter int LIMIT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [WORD_W-1:0] n,
  input  wire logic [WORD_W-1:0] p,
  input  wire logic [6:0]        digit_count,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  output div_req_t               div_req,
  input  wire div_rsp_t          div_rsp
);

  localparam int AW = $clog2(LIMIT);
  localparam int CW = $clog2(LIMIT + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIG  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_MODS = 8'b0010_0000,
    S_MOD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [63:0]       val_r, val_nxt;
  logic [WORD_W-1:0] base_r, base_nxt;
  logic              fixed_r, fixed_nxt;
  logic [CW-1:0]     target_r, target_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [31:0]       prod_r, prod_nxt;
  out_item_t         out_r, out_nxt;
  logic [WORD_W-1:0] rd_r;

  logic [WORD_W-1:0] mem [LIMIT];
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     ra;

  logic [WORD_W-1:0] n_m1, half;
  logic              is_last;
  logic [WORD_W-1:0] dig;
  logic              accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign n_m1     = n - WORD_W'(1);
  assign half     = {1'b0, n_m1[WORD_W-1:1]};
  // digits sit least significant first; emission walks them downward
  assign rd_idx   = cnt_r - CW'(1) - pos_r;
  assign ra       = rd_idx[AW-1:0];
  assign is_last  = (pos_r == cnt_r - CW'(1));
  assign dig      = (mode_r == MODE_PREFIX) ? {rd_r[WORD_W-2:0], ~is_last} : rd_r;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    val_nxt    = val_r;
    base_nxt   = base_r;
    fixed_nxt  = fixed_r;
    target_nxt = target_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    prod_nxt   = prod_r;
    out_nxt    = out_r;
    we         = 1'b0;
    wa         = cnt_r[AW-1:0];
    wd         = val_r[WORD_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = val_r;
    div_req.divisor  = base_r;
    div_req.steps    = STEPS_WIDE;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_data.mode;
          val_nxt    = in_data.value;
          cnt_nxt    = '0;
          pos_nxt    = '0;
          base_nxt   = n;
          fixed_nxt  = 1'b0;
          target_nxt = digit_count[CW-1:0];
          out_nxt    = '{word_index: '0, last: 1'b1, error: ERR_INVALID};
          state_nxt  = S_OUT;
          case (in_data.mode)
            MODE_MIN: begin
              if (n >= WORD_W'(2)) state_nxt = S_DIG;
            end
            MODE_FIXED: begin
              if (digit_count != 7'd0 && n >= WORD_W'(2)) begin
                if ({1'b0, digit_count} > 8'(LIMIT)) begin
                  out_nxt.error = ERR_RANGE;
                end else begin
                  fixed_nxt = 1'b1;
                  state_nxt = S_DIG;
                end
              end
            end
            MODE_PREFIX: begin
              if (n >= WORD_W'(3)) begin
                base_nxt = half;
                if (half == WORD_W'(1)) begin
                  // unit radix: only zero is representable, as one zero digit
                  if (in_data.value != 64'd0) begin
                    out_nxt.error = ERR_RANGE;
                  end else begin
                    we        = 1'b1;
                    wa        = '0;
                    wd        = '0;
                    cnt_nxt   = CW'(1);
                    state_nxt = S_RD;
                  end
                end else begin
                  state_nxt = S_DIG;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_DIG: begin
        if (fixed_r) begin
          if (cnt_r == target_r) begin
            if (val_r != 64'd0) begin
              out_nxt   = '{word_index: '0, last: 1'b1, error: ERR_RANGE};
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end else if (val_r < {48'd0, base_r}) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            val_nxt = '0;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          if (cnt_r >= CW'(LIMIT)) begin
            out_nxt   = '{word_index: '0, last: 1'b1, error: ERR_RANGE};
            state_nxt = S_OUT;
          end else if (val_r < {48'd0, base_r}) begin
            // top digit reached
            we        = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_RD;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          we        = 1'b1;
          wd        = div_rsp.remainder;
          cnt_nxt   = cnt_r + CW'(1);
          val_nxt   = div_rsp.quotient;
          state_nxt = S_DIG;
        end
      end

      S_RD: state_nxt = S_MUL;

      S_MUL: begin
        prod_nxt  = dig * p;
        state_nxt = S_MODS;
      end

      S_MODS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod_r, 32'd0};
        div_req.divisor  = n;
        div_req.steps    = STEPS_NARROW;
        state_nxt        = S_MOD;
      end

      S_MOD: begin
        if (div_rsp.done) begin
          out_nxt   = '{word_index: div_rsp.remainder, last: is_last, error: ERR_NONE};
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          if (out_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    val_r    <= val_nxt;
    base_r   <= base_nxt;
    fixed_r  <= fixed_nxt;
    target_r <= target_nxt;
    prod_r   <= prod_nxt;
    out_r    <= out_nxt;
  end

  // digit store: one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error != ERR_NONE) |-> out_data.last)
    else $error("error result without last");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LIMIT))
    else $error("digit count beyond store depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error == ERR_NONE) |-> pos_r < cnt_r)
    else $error("emit position past held digits");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV) || (state_r == S_MOD))
    else $error("divider finished with no waiting state");

endmodule

`default_nettype wire

>>> design/permuted_radix_digit_encoder.sv
// Permuted radix digit encoder top level: configuration registers and unit hookup.
//
// Usage: one input transfer (in_valid/in_stall, in_data = mode, value) produces one
// or more result transfers (out_valid/out_stall, out_data = word_index, last, error),
// most significant digit first; the final result of an item has last set. An error
// item yields a single result with last set and word_index zero.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready: index 0 word
// count N, 1 multiplier p, 2 digit count. The user must write it between items; the
// block does not enforce this. Timing: one item at a time; in_stall is high from
// acceptance until the last result is taken. The shared divider retires two quotient
// bits per cycle. A digit split off a value not below the radix goes through the divider,
// a digit below the radix is written directly, and each emitted digit goes through read,
// multiply, 32-bit modulo and output, plus any receiver stall. A fixed-mode value that
// does not fit splits every configured digit off through the divider before its error.
// A stalled result holds in the output register and the block waits.
// Reset (rst_n low at a clock edge, synchronous) returns to idle with N = 2, p = 1
// and digit count 1; the digit store needs no clearing.
`default_nettype none

module permuted_radix_digit_encoder import prd_pkg::*; #(
  parameter int MAX_DIGITS = 64,
  parameter int INDEX_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data
);

  localparam int LIMIT = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
  localparam logic [WORD_W-1:0] N_MASK = (INDEX_BITS >= WORD_W) ? {WORD_W{1'b1}} :
                                         WORD_W'((32'd1 << INDEX_BITS) - 32'd1);

  logic [WORD_W-1:0] word_count_r;
  logic [WORD_W-1:0] multiplier_r;
  logic [6:0]        digit_count_r;
  logic [WORD_W-1:0] n_eff;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign n_eff     = word_count_r & N_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r  <= WORD_W'(2);
      multiplier_r  <= WORD_W'(1);
      digit_count_r <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WORD_COUNT:  word_count_r  <= cfg_data;
        CFG_MULTIPLIER:  multiplier_r  <= cfg_data;
        CFG_DIGIT_COUNT: digit_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  prd_seq #(
    .LIMIT(LIMIT)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .n           (n_eff),
    .p           (multiplier_r),
    .digit_count (digit_count_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  prd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

`default_nettype wire
